### rtl/mep_pkg.sv
// Shared types and constants for the Mandelbrot escape pixel block.
// Used by every module under rtl; depends on nothing.
package mep_pkg;

    localparam int CoordW   = 32;    // Q4.28 coordinate width
    localparam int FracBits = 28;
    localparam int PixW     = 10;
    localparam int SizeW    = 11;    // screen size register width
    localparam int ZoomW    = 12;
    localparam int LimW     = 18;    // signed iteration limit
    localparam int CntW     = 17;    // iteration counter, holds the largest limit
    localparam int IdxW     = 20;
    localparam int ProdW    = CoordW + PixW;  // span times pixel
    localparam int SqW      = 2 * CoordW;     // exact Q8.56 square
    localparam int MaxDimDefault = 1024;

    localparam logic [SqW-1:0] EscapeBound = 64'd4 << (2 * FracBits);
    localparam logic signed [LimW-1:0] LimitBase  = 18'sd500;
    localparam logic signed [LimW-1:0] LimitScale = 18'sd45;

    typedef enum logic [2:0] {
        REG_REAL_MIN  = 3'd0,
        REG_IMAG_MIN  = 3'd1,
        REG_REAL_SPAN = 3'd2,
        REG_IMAG_SPAN = 3'd3,
        REG_WIDTH     = 3'd4,
        REG_HEIGHT    = 3'd5,
        REG_ZOOM      = 3'd6,
        REG_UNUSED    = 3'd7
    } cfg_idx_t;

    // One mapped point waiting for the iteration unit
    typedef struct packed {
        logic signed [CoordW-1:0] c_re;
        logic signed [CoordW-1:0] c_im;
        logic [IdxW-1:0]          pixel_index;
        logic signed [LimW-1:0]   limit;
    } point_t;

    // Settings the front part needs, held in the top level
    typedef struct packed {
        logic signed [CoordW-1:0] real_min;
        logic signed [CoordW-1:0] imag_min;
        logic signed [CoordW-1:0] real_span;
        logic signed [CoordW-1:0] imag_span;
        logic [SizeW-1:0]         screen_width;
        logic [SizeW-1:0]         screen_height;
        logic signed [ZoomW-1:0]  zoom_level;
    } cfg_t;

endpackage

### rtl/mep_div.sv
// Bit-serial restoring divider: unsigned dividend by a small unsigned divisor.
// Uses mep_pkg for widths; sequenced by mep_front.
module mep_div #(
    parameter int DimW = 11
) (
    input  logic                      clk,
    input  logic                      load,
    input  logic                      step,
    input  logic [mep_pkg::ProdW-1:0] dividend,
    input  logic [DimW-1:0]           divisor,
    output logic [mep_pkg::ProdW-1:0] quotient
);

    logic [mep_pkg::ProdW-1:0] quo_reg;
    logic [mep_pkg::ProdW-1:0] quo_next;
    logic [DimW-1:0]           rem_reg;
    logic [DimW-1:0]           rem_next;
    logic [DimW-1:0]           div_reg;
    logic [DimW:0]             trial;
    logic                      fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[mep_pkg::ProdW-1]};
        fits  = trial >= {1'b0, div_reg};
        if (fits)
        begin
            rem_next = DimW'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[DimW-1:0];
        end
        quo_next = {quo_reg[mep_pkg::ProdW-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;

endmodule

### rtl/mep_front.sv
// Front part: takes a pixel beat, maps it to the point c and its screen index.
// Uses mep_pkg and two mep_div instances; feeds mep_fifo.
module mep_front #(
    parameter int MaxDim = mep_pkg::MaxDimDefault
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mep_pkg::cfg_t            cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [mep_pkg::PixW-1:0] pixel_x,
    input  logic [mep_pkg::PixW-1:0] pixel_y,
    input  logic                     q_full,
    output logic                     q_push,
    output mep_pkg::point_t          q_data
);

    localparam int DimW  = $clog2(MaxDim + 1);
    localparam int StepW = $clog2(mep_pkg::ProdW + 1);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_DIV  = 4'b0100,
        F_FIN  = 4'b1000
    } fstate_t;

    fstate_t state_reg;
    fstate_t state_next;

    logic [StepW-1:0]              step_reg;
    logic [mep_pkg::PixW-1:0]      px_reg;
    logic [mep_pkg::PixW-1:0]      py_reg;
    logic                          neg_re_reg;
    logic                          neg_im_reg;
    logic [mep_pkg::IdxW-1:0]      idx_reg;
    logic [DimW-1:0]               dim_w;
    logic [DimW-1:0]               dim_h;
    logic signed [mep_pkg::ProdW-1:0] prod_re;
    logic signed [mep_pkg::ProdW-1:0] prod_im;
    logic [mep_pkg::ProdW-1:0]     mag_re;
    logic [mep_pkg::ProdW-1:0]     mag_im;
    logic [mep_pkg::ProdW-1:0]     quo_re;
    logic [mep_pkg::ProdW-1:0]     quo_im;
    logic                          div_load;
    logic                          div_step;
    logic signed [mep_pkg::CoordW-1:0] c_re;
    logic signed [mep_pkg::CoordW-1:0] c_im;
    logic signed [mep_pkg::LimW-1:0]   limit;

    function automatic logic [DimW-1:0] eff_dim(input logic [mep_pkg::SizeW-1:0] d);
        logic [DimW-1:0] r;
        if (d == '0)
        begin
            r = DimW'(1);
        end
        else if (32'(d) > 32'(MaxDim))
        begin
            r = DimW'(MaxDim);
        end
        else
        begin
            r = DimW'(d);
        end
        return r;
    endfunction

    // Signed quotient plus edge, clamped to the Q4.28 range
    function automatic logic signed [mep_pkg::CoordW-1:0] place(
        input logic signed [mep_pkg::CoordW-1:0] lo,
        input logic                              neg,
        input logic [mep_pkg::ProdW-1:0]         quo
    );
        logic signed [mep_pkg::ProdW:0]   sq;
        logic signed [mep_pkg::ProdW+1:0] sum;
        logic signed [mep_pkg::CoordW-1:0] r;
        sq  = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        sum = (mep_pkg::ProdW+2)'(lo) + (mep_pkg::ProdW+2)'(sq);
        if (sum > (mep_pkg::ProdW+2)'(32'sh7FFF_FFFF))
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (sum < -(mep_pkg::ProdW+2)'(64'sh8000_0000))
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = sum[mep_pkg::CoordW-1:0];
        end
        return r;
    endfunction

    assign dim_w    = eff_dim(cfg.screen_width);
    assign dim_h    = eff_dim(cfg.screen_height);
    assign in_ready = (state_reg == F_IDLE);

    assign prod_re = cfg.real_span * $signed({1'b0, px_reg});
    assign prod_im = cfg.imag_span * $signed({1'b0, py_reg});
    assign mag_re  = prod_re[mep_pkg::ProdW-1] ? mep_pkg::ProdW'(-prod_re)
                                               : mep_pkg::ProdW'(prod_re);
    assign mag_im  = prod_im[mep_pkg::ProdW-1] ? mep_pkg::ProdW'(-prod_im)
                                               : mep_pkg::ProdW'(prod_im);

    assign div_load = (state_reg == F_MUL);
    assign div_step = (state_reg == F_DIV);

    mep_div #(.DimW(DimW)) u_div_re (
        .clk      (clk),
        .load     (div_load),
        .step     (div_step),
        .dividend (mag_re),
        .divisor  (dim_w),
        .quotient (quo_re)
    );

    mep_div #(.DimW(DimW)) u_div_im (
        .clk      (clk),
        .load     (div_load),
        .step     (div_step),
        .dividend (mag_im),
        .divisor  (dim_h),
        .quotient (quo_im)
    );

    assign c_re  = place(cfg.real_min, neg_re_reg, quo_re);
    assign c_im  = place(cfg.imag_min, neg_im_reg, quo_im);
    assign limit = $signed({{(mep_pkg::LimW-mep_pkg::ZoomW){cfg.zoom_level[mep_pkg::ZoomW-1]}},
                            cfg.zoom_level}) * mep_pkg::LimitScale + mep_pkg::LimitBase;

    assign q_push = (state_reg == F_FIN) && !q_full;
    assign q_data = '{c_re: c_re, c_im: c_im, pixel_index: idx_reg, limit: limit};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_DIV;
            end
            F_DIV:
            begin
                if (step_reg == StepW'(mep_pkg::ProdW - 1))
                begin
                    state_next = F_FIN;
                end
            end
            F_FIN:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (state_reg == F_MUL)
        begin
            neg_re_reg <= prod_re[mep_pkg::ProdW-1];
            neg_im_reg <= prod_im[mep_pkg::ProdW-1];
            idx_reg    <= mep_pkg::IdxW'(py_reg * dim_w + (mep_pkg::PixW+DimW)'(px_reg));
        end
    end

endmodule

### rtl/mep_fifo.sv
// Two-entry queue of mapped points between the front and the iteration unit.
// Uses mep_pkg::point_t.
module mep_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mep_pkg::point_t push_data,
    input  logic            pop,
    output mep_pkg::point_t pop_data,
    output logic            full,
    output logic            empty
);

    mep_pkg::point_t mem_reg [2];
    logic            wptr_reg;
    logic            rptr_reg;
    logic [1:0]      count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### rtl/mep_iter.sv
// Back part: iterates z = z*z + c on one point and holds the result beat.
// Uses mep_pkg; reads points from mep_fifo.
module mep_iter (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  mep_pkg::point_t          q_data,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [mep_pkg::IdxW-1:0] out_index,
    output logic                     out_inside
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_CHK  = 4'b0100,
        B_DONE = 4'b1000
    } bstate_t;

    bstate_t state_reg;

    logic signed [mep_pkg::CoordW-1:0] zr_reg;
    logic signed [mep_pkg::CoordW-1:0] zi_reg;
    logic signed [mep_pkg::CoordW-1:0] cr_reg;
    logic signed [mep_pkg::CoordW-1:0] ci_reg;
    logic signed [mep_pkg::LimW-1:0]   lim_reg;
    logic [mep_pkg::IdxW-1:0]          idx_reg;
    logic [mep_pkg::CntW-1:0]          cnt_reg;
    logic signed [mep_pkg::SqW-1:0]    sqr_reg;
    logic signed [mep_pkg::SqW-1:0]    sqi_reg;
    logic signed [mep_pkg::SqW-1:0]    crs_reg;
    logic                              inside_reg;
    logic                              out_valid_reg;
    logic [mep_pkg::IdxW-1:0]          out_index_reg;
    logic                              out_inside_reg;

    logic [mep_pkg::SqW-1:0]           mag;
    logic                              escape;
    logic                              at_limit;
    logic signed [mep_pkg::SqW-1:0]    diff_sh;
    logic signed [mep_pkg::SqW-1:0]    crs_sh;
    logic                              out_load;

    assign mag      = $unsigned(sqr_reg) + $unsigned(sqi_reg);
    assign escape   = mag > mep_pkg::EscapeBound;
    assign at_limit = $signed({1'b0, cnt_reg}) >= lim_reg;
    assign diff_sh  = (sqr_reg - sqi_reg) >>> mep_pkg::FracBits;
    assign crs_sh   = crs_reg >>> (mep_pkg::FracBits - 1);

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign out_load = (state_reg == B_DONE) && (!out_valid_reg || out_ready);

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_inside = out_inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    state_reg <= B_CHK;
                end
                B_CHK:
                begin
                    if (escape || at_limit)
                    begin
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        state_reg <= B_MUL;
                    end
                end
                B_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The first pass checks z = c, which is the bound test on c itself
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            zr_reg  <= q_data.c_re;
            zi_reg  <= q_data.c_im;
            cr_reg  <= q_data.c_re;
            ci_reg  <= q_data.c_im;
            lim_reg <= q_data.limit;
            idx_reg <= q_data.pixel_index;
            cnt_reg <= mep_pkg::CntW'(1);
        end
        if (state_reg == B_MUL)
        begin
            sqr_reg <= zr_reg * zr_reg;
            sqi_reg <= zi_reg * zi_reg;
            crs_reg <= zr_reg * zi_reg;
        end
        if (state_reg == B_CHK)
        begin
            inside_reg <= !escape;
            zr_reg     <= diff_sh[mep_pkg::CoordW-1:0] + cr_reg;
            zi_reg     <= crs_sh[mep_pkg::CoordW-1:0] + ci_reg;
            cnt_reg    <= cnt_reg + 1'b1;
        end
        if (out_load)
        begin
            out_index_reg  <= idx_reg;
            out_inside_reg <= inside_reg;
        end
    end

    a_chk_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_MUL) |=> (state_reg == B_CHK))
        else $error("check step did not follow multiply");

    a_escape_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CHK && escape) |=> (state_reg == B_DONE && !inside_reg))
        else $error("escaped point not marked outside");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == B_IDLE))
        else $error("result load lost");

endmodule

### rtl/mandelbrot_escape_pixel.sv
// Mandelbrot escape test per pixel. Front part maps a pixel with a bit-serial
// divide of 42 steps; back part runs each iteration as a multiply, then a check
// and update. Latency is front plus back; throughput is set by the iteration loop.
// A two-entry queue lets the front map the next pixel while the back iterates.
// rst_n clears control and loads the configuration reset values.
module mandelbrot_escape_pixel #(
    parameter int MAX_DIM = mep_pkg::MaxDimDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // pixel_x[9:0], pixel_y[19:10], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // pixel_index[19:0], inside_res[20], zeros
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    mep_pkg::cfg_t   cfg_reg;
    mep_pkg::point_t push_data;
    mep_pkg::point_t pop_data;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    logic [mep_pkg::IdxW-1:0] pixel_index;
    logic            inside_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_min      <= -32'sd536870912;
            cfg_reg.imag_min      <= 32'sd268435456;
            cfg_reg.real_span     <= 32'sd805306368;
            cfg_reg.imag_span     <= -32'sd536870912;
            cfg_reg.screen_width  <= 11'd80;
            cfg_reg.screen_height <= 11'd24;
            cfg_reg.zoom_level    <= '0;
        end
        else if (cfg_we)
        begin
            case (mep_pkg::cfg_idx_t'(cfg_addr))
                mep_pkg::REG_REAL_MIN:  cfg_reg.real_min      <= cfg_wdata;
                mep_pkg::REG_IMAG_MIN:  cfg_reg.imag_min      <= cfg_wdata;
                mep_pkg::REG_REAL_SPAN: cfg_reg.real_span     <= cfg_wdata;
                mep_pkg::REG_IMAG_SPAN: cfg_reg.imag_span     <= cfg_wdata;
                mep_pkg::REG_WIDTH:     cfg_reg.screen_width  <= cfg_wdata[10:0];
                mep_pkg::REG_HEIGHT:    cfg_reg.screen_height <= cfg_wdata[10:0];
                mep_pkg::REG_ZOOM:      cfg_reg.zoom_level    <= cfg_wdata[11:0];
                default:
                begin
                end
            endcase
        end
    end

    mep_front #(.MaxDim(MAX_DIM)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .pixel_x  (s_tdata[9:0]),
        .pixel_y  (s_tdata[19:10]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    mep_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    mep_iter u_iter (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (pop_data),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (pixel_index),
        .out_inside (inside_res)
    );

    assign m_tdata = {3'b000, inside_res, pixel_index};

endmodule

### dv/mandelbrot_escape_pixel_tb.sv
// Self-checking testbench for mandelbrot_escape_pixel: drives pixel beats, predicts the
// escape result in Q4.28 and compares every output beat. Depends on rtl/mep_pkg.sv.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_tb;

    typedef struct {
        logic [mep_pkg::PixW-1:0] px;
        logic [mep_pkg::PixW-1:0] py;
    } pixel_t;

    typedef struct {
        logic [mep_pkg::IdxW-1:0] idx;
        logic                     bounded;
    } verdict_t;

    localparam longint One = 64'sd1 << mep_pkg::FracBits;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    // shadow copy of the settings, changed only while the block is idle
    logic signed [mep_pkg::CoordW-1:0] sh_real_min  = -32'sd536870912;
    logic signed [mep_pkg::CoordW-1:0] sh_imag_min  = 32'sd268435456;
    logic signed [mep_pkg::CoordW-1:0] sh_real_span = 32'sd805306368;
    logic signed [mep_pkg::CoordW-1:0] sh_imag_span = -32'sd536870912;
    logic [mep_pkg::SizeW-1:0]         sh_width     = 11'd80;
    logic [mep_pkg::SizeW-1:0]         sh_height    = 11'd24;
    logic signed [mep_pkg::ZoomW-1:0]  sh_zoom      = '0;

    pixel_t   pixel_q[$];
    verdict_t verdict_q[$];
    int       fails = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       stall_mode = 0;
    int       stall_left = 0;

    mandelbrot_escape_pixel i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic longint eff_dim(logic [mep_pkg::SizeW-1:0] d);
        if (d == 0)
            return 1;
        if (d > mep_pkg::MaxDimDefault)
            return mep_pkg::MaxDimDefault;
        return longint'(d);
    endfunction

    function automatic longint map_axis(longint lo, longint span, longint pix, longint dim);
        longint r;
        r = lo + (span * pix) / dim;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r;
    endfunction

    function automatic bit escaped(longint a, longint b);
        logic [63:0] mag;
        mag = a * a + b * b;
        return mag > mep_pkg::EscapeBound;
    endfunction

    function automatic verdict_t escape_verdict(pixel_t p);
        verdict_t v;
        longint   w;
        longint   h;
        longint   cr;
        longint   ci;
        longint   zr;
        longint   zi;
        longint   nr;
        longint   lim;
        w   = eff_dim(sh_width);
        h   = eff_dim(sh_height);
        cr  = map_axis(sh_real_min, sh_real_span, longint'(p.px), w);
        ci  = map_axis(sh_imag_min, sh_imag_span, longint'(p.py), h);
        lim = longint'(sh_zoom) * 45 + 500;
        v.idx     = mep_pkg::IdxW'(longint'(p.py) * w + longint'(p.px));
        v.bounded = 1'b1;
        if (escaped(cr, ci))
        begin
            v.bounded = 1'b0;
        end
        else
        begin
            zr = 0;
            zi = 0;
            for (longint i = 0; i < lim; i++)
            begin
                nr = ((zr * zr - zi * zi) >>> mep_pkg::FracBits) + cr;
                zi = ((2 * zr * zi) >>> mep_pkg::FracBits) + ci;
                zr = nr;
                if (escaped(zr, zi))
                begin
                    v.bounded = 1'b0;
                    break;
                end
            end
        end
        return v;
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t p;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                p.px = s_tdata[9:0];
                p.py = s_tdata[19:10];
                verdict_q = {verdict_q, escape_verdict(p)};
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_q.size() > 0)
                begin
                    p = pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, p.py, p.px};
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each beat, stall on its own pattern
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t exp_v;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected result beat %h", m_tdata);
                    fails++;
                end
                else
                begin
                    exp_v = verdict_q.pop_front();
                    if (m_tdata[19:0] !== exp_v.idx)
                    begin
                        $error("pixel_index expected %0d got %0d", exp_v.idx, m_tdata[19:0]);
                        fails++;
                    end
                    if (m_tdata[20] !== exp_v.bounded)
                    begin
                        $error("inside_res expected %0d got %0d", exp_v.bounded, m_tdata[20]);
                        fails++;
                    end
                end
            end
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(20, 300);
            end
            else
            begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_reg(mep_pkg::cfg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            mep_pkg::REG_REAL_MIN:  sh_real_min  = val;
            mep_pkg::REG_IMAG_MIN:  sh_imag_min  = val;
            mep_pkg::REG_REAL_SPAN: sh_real_span = val;
            mep_pkg::REG_IMAG_SPAN: sh_imag_span = val;
            mep_pkg::REG_WIDTH:     sh_width     = val[mep_pkg::SizeW-1:0];
            mep_pkg::REG_HEIGHT:    sh_height    = val[mep_pkg::SizeW-1:0];
            mep_pkg::REG_ZOOM:      sh_zoom      = val[mep_pkg::ZoomW-1:0];
            default: ;
        endcase
    endtask

    task automatic setup(longint rmin, longint imin, longint rspan, longint ispan,
                         int w, int h, int zoom);
        write_reg(mep_pkg::REG_REAL_MIN, rmin[31:0]);
        write_reg(mep_pkg::REG_IMAG_MIN, imin[31:0]);
        write_reg(mep_pkg::REG_REAL_SPAN, rspan[31:0]);
        write_reg(mep_pkg::REG_IMAG_SPAN, ispan[31:0]);
        write_reg(mep_pkg::REG_WIDTH, 32'(w));
        write_reg(mep_pkg::REG_HEIGHT, 32'(h));
        write_reg(mep_pkg::REG_ZOOM, 32'(zoom));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_pixel(int x, int y);
        pixel_t p;
        p.px = mep_pkg::PixW'(x);
        p.py = mep_pkg::PixW'(y);
        pixel_q = {pixel_q, p};
    endtask

    // hold until every pixel went through and every result came back
    task automatic drain();
        while (pixel_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int w;
        int h;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset view: corners, center, off-screen and all-ones pixels
        add_pixel(0, 0);
        add_pixel(79, 23);
        add_pixel(53, 12);
        add_pixel(40, 12);
        add_pixel(1023, 1023);
        add_pixel(80, 0);
        add_pixel(0, 24);
        add_pixel(1023, 0);
        drain();

        // saturating extremes, zero width, oversized height, unknown register ignored
        setup(-64'sd2147483648, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648,
              0, 2047, -11);
        write_reg(mep_pkg::REG_UNUSED, 32'hFFFF_FFFF);
        @(posedge clk);
        cfg_we <= 1'b0;
        add_pixel(0, 0);
        add_pixel(1023, 1023);
        add_pixel(1, 512);
        add_pixel(1023, 0);
        drain();

        // largest index with widest screen, negative limit far below zero
        setup(0, 0, One / 4, One / 4, 2047, 2047, -2048);
        add_pixel(1023, 1023);
        add_pixel(0, 1023);
        add_pixel(512, 512);
        drain();

        // highest zoom of this bench: c = 0 runs the full limit, far points leave at once
        setup(0, 0, 0, 0, 1024, 1024, 1445);
        add_pixel(5, 7);
        drain();
        setup(-3 * One, 2 * One, -One, One, 1, 1, 1445);
        add_pixel(0, 0);
        add_pixel(3, 1);
        drain();

        for (int ph = 0; ph < 11; ph++)
        begin
            if (ph % 4 == 3)
            begin
                setup($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 4095));
                // keep heavy limits out of the random part
                if (sh_zoom > 0)
                begin
                    write_reg(mep_pkg::REG_ZOOM, 32'(-12'sd11));
                    @(posedge clk);
                    cfg_we <= 1'b0;
                end
            end
            else
            begin
                setup(-longint'($urandom_range(0, 2 * 268435456)) - One / 2,
                      longint'($urandom_range(0, 268435456)) + One / 4,
                      longint'($urandom_range(One / 2, 3 * One)),
                      -longint'($urandom_range(One / 2, 2 * One)),
                      $urandom_range(1, 1024), $urandom_range(1, 1024),
                      ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2))
                                                  : -int'($urandom_range(3, 11)));
            end
            w = int'(eff_dim(sh_width));
            h = int'(eff_dim(sh_height));
            for (int n = 0; n < 105; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
                else
                    add_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
rtl/mep_pkg.sv
rtl/mep_div.sv
rtl/mep_front.sv
rtl/mep_fifo.sv
rtl/mep_iter.sv
rtl/mandelbrot_escape_pixel.sv
dv/mandelbrot_escape_pixel_tb.sv
